// File: rtl/ddr_picos_to_clocks_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the picosecond to memory clock converter
// Shared helpers that wrap concurrent assertions on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef DDR_PICOS_TO_CLOCKS_DEFINES_SVH
`define DDR_PICOS_TO_CLOCKS_DEFINES_SVH

// Checks an implication in the same cycle.
`define DPTC_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("dptc assertion failed");

// Checks an implication in the next cycle.
`define DPTC_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("dptc assertion failed");

`endif

// File: rtl/dptc_pkg.sv
// ----------------------------------------------------------------------------
// dptc_pkg
// Constants for the picosecond to memory clock conversion.
// ----------------------------------------------------------------------------
`default_nettype none
package dptc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DIVD_W = 41;
  localparam int unsigned QEST_W = 24;

  // 2e12 = 5^12 * 2^13
  localparam logic [DIVD_W-1:0] TWO_E12   = 41'd2000000000000;
  localparam logic [27:0]       FIVE_P12  = 28'd244140625;
  localparam logic [QEST_W-1:0] RECIP_D   = 24'd9223372;
  localparam logic [5:0]        LAST_STEP = 6'(DIVD_W - 1);

endpackage
`default_nettype wire

// File: rtl/ddr_picos_to_clocks.sv
// Pipeline: five register stages that a result item passes through in order.
// Throughput: one item per cycle while the divider is idle; any stage holds
// its item under back-pressure.
// A rate write starts a serial divider for the clock period, one quotient bit
// per cycle, followed by one rounding step; input is held off until the rounded
// period is stored. Reset (synchronous, rst_n low) clears the rate and the
// period to zero and empties the pipeline.
// ----------------------------------------------------------------------------
// ddr_picos_to_clocks
// Converts picoseconds into memory clocks for the configured data rate and
// reports the rounded clock period with every item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ddr_picos_to_clocks_defines.svh"
module ddr_picos_to_clocks
  import dptc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,     // mem_rate
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // picos
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata      // mclk [31:0], period_ps [63:32]
);

  logic [WORD_W-1:0] rate_r, period_r;
  logic              busy_r, fin_r;
  logic [5:0]        cnt_r;
  logic [WORD_W-1:0] rem_r;
  logic [DIVD_W-1:0] quo_r;

  logic [WORD_W:0]   dv_shift;
  logic              dv_ge;
  logic [DIVD_W:0]   dv_qf;

  logic [4:0]        v_r;
  logic [4:0]        rdy;
  logic [63:0]       p1_r, p2_r, p3_r;
  logic [QEST_W-1:0] qe2_r, qe3_r, q4_r;
  logic [51:0]       m3_r;
  logic [DIVD_W-1:0] rem4_r;
  logic [WORD_W-1:0] mclk_r;

  logic [55:0]       qe_full;
  logic [63:0]       rem0;
  logic              rem_ge;
  logic [63:0]       rem_sub;

  always_comb begin
    dv_shift = {rem_r, quo_r[DIVD_W-1]};
    dv_ge    = dv_shift >= {1'b0, rate_r};
    dv_qf    = {1'b0, quo_r} + {{DIVD_W{1'b0}}, (rem_r >= (rate_r >> 1))};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r   <= '0;
      period_r <= '0;
      busy_r   <= 1'b0;
      fin_r    <= 1'b0;
      cnt_r    <= '0;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
      busy_r <= 1'b1;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= TWO_E12;
    end else if (busy_r) begin
      rem_r <= dv_ge ? WORD_W'(dv_shift - {1'b0, rate_r}) : dv_shift[WORD_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], dv_ge};
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == LAST_STEP) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else if (fin_r) begin
      fin_r <= 1'b0;
      if (rate_r == '0) begin
        period_r <= '0;
      end else if (dv_qf[DIVD_W:WORD_W] != '0) begin
        period_r <= '1;
      end else begin
        period_r <= dv_qf[WORD_W-1:0];
      end
    end
  end

  always_comb begin
    rdy[4] = !v_r[4] || out_tready;
    rdy[3] = !v_r[3] || rdy[4];
    rdy[2] = !v_r[2] || rdy[3];
    rdy[1] = !v_r[1] || rdy[2];
    rdy[0] = !v_r[0] || rdy[1];
    in_tready = rdy[0] && !busy_r && !fin_r;
    qe_full = p1_r[63:32] * RECIP_D;
    rem0    = p3_r - {m3_r[50:0], 13'd0};
    rem_ge  = rem0 >= {23'd0, TWO_E12};
    rem_sub = rem0 - {23'd0, TWO_E12};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_tvalid && in_tready;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
      if (rdy[4]) v_r[4] <= v_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) p1_r <= in_tdata * rate_r;
    if (rdy[1]) begin
      p2_r  <= p1_r;
      qe2_r <= qe_full[55:32];
    end
    if (rdy[2]) begin
      p3_r  <= p2_r;
      qe3_r <= qe2_r;
      m3_r  <= qe2_r * FIVE_P12;
    end
    if (rdy[3]) begin
      q4_r   <= qe3_r + QEST_W'(rem_ge);
      rem4_r <= rem_ge ? rem_sub[DIVD_W-1:0] : rem0[DIVD_W-1:0];
    end
    if (rdy[4]) begin
      mclk_r <= WORD_W'(q4_r) + WORD_W'(rem4_r > {9'd0, rate_r});
    end
  end

  assign out_tvalid = v_r[4];
  assign out_tdata  = {period_r, mclk_r};

  `DPTC_ASSERT_NOW(a_hold_in_busy, busy_r || fin_r, !in_tready)
  `DPTC_ASSERT_NEXT(a_cfg_starts_div, cfg_we, busy_r)
  `DPTC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata))

endmodule
`default_nettype wire

// File: bench/tb_ddr_picos_to_clocks.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the picosecond to memory clock converter
// Streams picosecond values through the block under several data rates and
// compares every result, cycle count and clock period, with a model of the
// conversion kept in the bench. Both sides of the stream idle at random outside the stall-free phases.
// ----------------------------------------------------------------------------
`default_nettype none

class clock_count_board;
  logic [63:0] pending[$];
  bit [31:0]   rate;
  int          errors;

  function logic [31:0] cycles_for(bit [31:0] ps);
    bit [63:0] prod;
    bit [63:0] quo;
    bit [63:0] rem;
    if (ps == 0 || rate == 0) return 32'd0;
    prod = {32'd0, ps} * {32'd0, rate};
    quo = prod / 64'd2000000000000;
    rem = prod % 64'd2000000000000;
    if (rem > {32'd0, rate}) quo++;
    if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
    return quo[31:0];
  endfunction

  function logic [31:0] period_for();
    bit [63:0] quo;
    bit [63:0] rem;
    if (rate == 0) return 32'd0;
    quo = 64'd2000000000000 / {32'd0, rate};
    rem = 64'd2000000000000 % {32'd0, rate};
    if (rem >= {33'd0, rate[31:1]}) quo++;
    if (quo > 64'hFFFF_FFFF) quo = 64'hFFFF_FFFF;
    return quo[31:0];
  endfunction

  function void note_input(bit [31:0] ps);
    pending.push_back({period_for(), cycles_for(ps)});
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h (rate %0d)", what, got, want, rate);
    errors++;
  endtask

  task check_result(logic [63:0] got);
    logic [63:0] exp_word;
    if (pending.size() == 0) begin
      report("result with nothing pending", got, 64'd0);
      return;
    end
    exp_word = pending.pop_front();
    if (got[31:0] !== exp_word[31:0]) report("mclk", got, exp_word);
    if (got[63:32] !== exp_word[63:32]) report("period_ps", got, exp_word);
  endtask
endclass

module tb_ddr_picos_to_clocks;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;         // picos
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;             // mclk [31:0], period_ps [63:32]
  bit          stall_free = 1'b0;

  clock_count_board board = new();

  ddr_picos_to_clocks u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  initial begin
    int n;
    forever begin
      @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_picos(input logic [31:0] ps);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ps;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_input(ps);
  endtask

  task automatic set_rate(input logic [31:0] r);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.rate = r;
  endtask

  function automatic logic [31:0] random_picos();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 100000);
      3: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] random_rate();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 1000);
      3: return $urandom_range(800000000, 3200000000);
      4: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] rates[8];
    rates = '{32'd0, 32'd1, 32'd465, 32'd466, 32'd1600000000,
              32'd2000000000, 32'd3200000000, 32'hFFFF_FFFF};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_picos(32'd0);
    send_picos(32'd12345);
    foreach (rates[i]) begin
      set_rate(rates[i]);
      send_picos(32'd0);
      send_picos(32'd1);
      send_picos(32'hFFFF_FFFF);
      send_picos(32'd13750);
    end
    for (int ph = 0; ph < 25; ph++) begin
      set_rate(random_rate());
      stall_free = (ph % 5 == 4);
      repeat (50) send_picos(random_picos());
    end
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

`default_nettype wire
